### hw/rtl/cfba_pkg.sv
`default_nettype none

package cfba_pkg;

  localparam int BLOCK_W = 10;
  localparam int STATUS_W = 2;
  localparam int COUNT_W = 11;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NO_FREE = 2'd1,
    ST_RANGE   = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;        // latch the request fields
    logic    cap_gnt;     // capture the cache word at the pointer
    logic    pop;         // pointer up, count down
    logic    push;        // write the block below the pointer, pointer down
    logic    base_ld;     // load the chain address for a copy
    logic    copy_en;     // run the copy engine
    logic    reload_fin;  // pointer to zero after a reload, count down
    logic    spill_fin;   // block into the top slot after a spill
    logic    finish;      // register the result
    status_e status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_free;
    logic count_zero;
    logic count_gt1;
    logic ptr_empty;
    logic ptr_zero;
    logic ptr_top;
    logic blk_bad;
    logic gnt_bad;
    logic copy_done;
  } sts_t;

endpackage

`default_nettype wire

### hw/rtl/cfba_ram.sv
`default_nettype none

module cfba_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 100
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### hw/rtl/cfba_ctrl.sv
`default_nettype none

module cfba_ctrl
  import cfba_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_AREAD = 3'd2;
  localparam logic [2:0] S_ADEC  = 3'd3;
  localparam logic [2:0] S_BASE  = 3'd4;
  localparam logic [2:0] S_COPY  = 3'd5;
  localparam logic [2:0] S_SPILL = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    cmd_o.status = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.is_free) begin
          if (sts_i.blk_bad) begin
            cmd_o.finish = 1'b1;
            cmd_o.status = ST_RANGE;
            state_d = S_IDLE;
          end else if (sts_i.ptr_zero) begin
            state_d = S_BASE;
          end else begin
            cmd_o.push = 1'b1;
            cmd_o.finish = 1'b1;
            state_d = S_IDLE;
          end
        end else if (sts_i.count_zero || sts_i.ptr_empty) begin
          cmd_o.finish = 1'b1;
          cmd_o.status = ST_NO_FREE;
          state_d = S_IDLE;
        end else begin
          state_d = S_AREAD;
        end
      end
      S_AREAD: begin
        state_d = S_ADEC;
      end
      S_ADEC: begin
        cmd_o.cap_gnt = 1'b1;
        // The top slot holds a chain link only while more than one block is free.
        if (sts_i.count_gt1 && sts_i.ptr_top && !sts_i.gnt_bad) begin
          state_d = S_BASE;
        end else begin
          cmd_o.pop = 1'b1;
          cmd_o.finish = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_BASE: begin
        cmd_o.base_ld = 1'b1;
        state_d = S_COPY;
      end
      S_COPY: begin
        cmd_o.copy_en = 1'b1;
        if (sts_i.copy_done) begin
          if (sts_i.is_free) begin
            state_d = S_SPILL;
          end else begin
            cmd_o.reload_fin = 1'b1;
            cmd_o.finish = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      S_SPILL: begin
        cmd_o.spill_fin = 1'b1;
        cmd_o.finish = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

### hw/rtl/cfba_dp.sv
`default_nettype none

module cfba_dp
  import cfba_pkg::*;
#(
  parameter int BLOCK_COUNT = 1024,
  parameter int CACHE_SLOTS = 100
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               req_type_i,
  input  wire logic [BLOCK_W-1:0] block_index_i,
  input  wire cmd_t               cmd_i,
  output sts_t                    sts_o,
  output logic                    done_o,
  output logic [BLOCK_W-1:0]      granted_block_o,
  output logic [STATUS_W-1:0]     status_o
);

  localparam int IW = $clog2(CACHE_SLOTS);
  localparam int PW = $clog2(CACHE_SLOTS + 1);
  localparam int CHAIN_DEPTH = BLOCK_COUNT * CACHE_SLOTS;
  localparam int CAW = $clog2(CHAIN_DEPTH);
  localparam logic [PW-1:0] PTR_EMPTY = PW'(CACHE_SLOTS);
  localparam logic [PW-1:0] PTR_TOP = PW'(CACHE_SLOTS - 1);
  localparam logic [IW-1:0] IDX_TOP = IW'(CACHE_SLOTS - 1);

  logic               req_q;
  logic [BLOCK_W-1:0] blk_q, gnt_q, granted_q, granted_d;
  logic [PW-1:0]      ptr_q, ptr_d, ptr_dec, cnt_q, cnt_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               wen_q, wen_d, done_q;
  logic [IW-1:0]      widx_q;
  logic [CAW-1:0]     caddr_q, caddr_d, waddr_q, base_w;
  status_e            status_q;

  logic               cache_we;
  logic [IW-1:0]      cache_waddr, cache_raddr;
  logic [BLOCK_W-1:0] cache_wdata, cache_rdata, chain_rdata, src_blk, fin_gnt;
  logic               chain_we, reload;

  assign reload  = (req_q == REQ_ALLOC);
  assign ptr_dec = ptr_q - PW'(1);
  assign src_blk = reload ? gnt_q : blk_q;
  assign base_w  = CAW'(src_blk) * CAW'(CACHE_SLOTS);
  assign fin_gnt = cmd_i.cap_gnt ? cache_rdata : gnt_q;

  // Cache port steering.
  assign cache_raddr = (cmd_i.copy_en && !reload) ? cnt_q[IW-1:0] : ptr_q[IW-1:0];
  assign cache_we    = (cmd_i.copy_en && reload && wen_q) || cmd_i.push || cmd_i.spill_fin;
  assign cache_waddr = cmd_i.push ? ptr_dec[IW-1:0] :
                       (cmd_i.spill_fin ? IDX_TOP : widx_q);
  assign cache_wdata = cmd_i.copy_en ? chain_rdata : blk_q;
  assign chain_we    = cmd_i.copy_en && !reload && wen_q;

  cfba_ram #(
    .WIDTH(BLOCK_W),
    .DEPTH(CACHE_SLOTS)
  ) u_cache (
    .clk_i  (clk_i),
    .we_i   (cache_we),
    .waddr_i(cache_waddr),
    .wdata_i(cache_wdata),
    .raddr_i(cache_raddr),
    .rdata_o(cache_rdata)
  );

  cfba_ram #(
    .WIDTH(BLOCK_W),
    .DEPTH(CHAIN_DEPTH)
  ) u_chain (
    .clk_i  (clk_i),
    .we_i   (chain_we),
    .waddr_i(waddr_q),
    .wdata_i(cache_rdata),
    .raddr_i(caddr_q),
    .rdata_o(chain_rdata)
  );

  always_comb begin
    ptr_d = ptr_q;
    count_d = count_q;
    if (cmd_i.pop) begin
      ptr_d = ptr_q + PW'(1);
      count_d = count_q - COUNT_W'(1);
    end
    if (cmd_i.reload_fin) begin
      ptr_d = '0;
      count_d = count_q - COUNT_W'(1);
    end
    if (cmd_i.push || cmd_i.spill_fin) begin
      ptr_d = cmd_i.push ? ptr_dec : PTR_TOP;
      if (count_q != COUNT_MAX) begin
        count_d = count_q + COUNT_W'(1);
      end
    end
  end

  // Copy engine: one read per cycle, each write follows in the cycle after its read.
  always_comb begin
    cnt_d = cnt_q;
    caddr_d = caddr_q;
    wen_d = 1'b0;
    if (cmd_i.base_ld) begin
      cnt_d = '0;
      caddr_d = base_w;
    end else if (cmd_i.copy_en && (cnt_q != PTR_EMPTY)) begin
      cnt_d = cnt_q + PW'(1);
      caddr_d = caddr_q + CAW'(1);
      wen_d = 1'b1;
    end
  end

  assign granted_d = (cmd_i.status == ST_OK && reload) ? fin_gnt : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q   <= PTR_EMPTY;
      count_q <= '0;
      cnt_q   <= '0;
      wen_q   <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      ptr_q   <= ptr_d;
      count_q <= count_d;
      cnt_q   <= cnt_d;
      wen_q   <= wen_d;
      done_q  <= cmd_i.finish;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_type_i;
      blk_q <= block_index_i;
    end
    if (cmd_i.cap_gnt) begin
      gnt_q <= cache_rdata;
    end
    caddr_q <= caddr_d;
    waddr_q <= caddr_q;
    widx_q  <= cnt_q[IW-1:0];
    if (cmd_i.finish) begin
      granted_q <= granted_d;
      status_q  <= cmd_i.status;
    end
  end

  always_comb begin
    sts_o.is_free    = (req_q == REQ_FREE);
    sts_o.count_zero = (count_q == '0);
    sts_o.count_gt1  = (count_q > COUNT_W'(1));
    sts_o.ptr_empty  = (ptr_q >= PTR_EMPTY);
    sts_o.ptr_zero   = (ptr_q == '0);
    sts_o.ptr_top    = (ptr_q == PTR_TOP);
    sts_o.blk_bad    = (32'(blk_q) >= BLOCK_COUNT);
    sts_o.gnt_bad    = (32'(cache_rdata) >= BLOCK_COUNT);
    sts_o.copy_done  = (cnt_q == PTR_EMPTY) && !wen_q;
  end

  assign done_o          = done_q;
  assign granted_block_o = granted_q;
  assign status_o        = status_q;

endmodule

`default_nettype wire

### hw/rtl/chained_free_block_allocator.sv
// Chained free-block allocator.
// A request is taken at a rising edge where start is high and busy is low:
// req_type_i selects allocate (0) or free (1); block_index_i names the block
// being freed. Each request gives exactly one result item on granted_block_o
// and status_o, shown for one cycle while done_o is high. The receiver cannot
// stall; it must take the result in that cycle.
// A free that pushes into the cache or fails its range check and an allocate
// that finds no free block finish from the check state; an ordinary allocate
// first does a registered cache read of the word at the pointer. A free into
// a full cache spills the cache into the chain memory and an allocate of the
// chain link reloads it: both run one copy of CACHE_SLOTS words through a
// single read and a single write port.
// One request is handled at a time; busy stays high until the result is
// registered, so the next request may be accepted in the cycle its
// predecessor's result is shown.
// Reset empties the cache and clears the free count; no memory clearing pass
// is run, so the block is ready right after reset.
`default_nettype none

module chained_free_block_allocator
  import cfba_pkg::*;
#(
  parameter int BLOCK_COUNT = 1024,
  parameter int CACHE_SLOTS = 100
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic                req_type_i,
  input  wire logic [BLOCK_W-1:0]  block_index_i,
  output logic                     done_o,
  output logic [BLOCK_W-1:0]       granted_block_o,
  output logic [STATUS_W-1:0]      status_o
);

  cmd_t cmd;
  sts_t sts;

  cfba_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .sts_i (sts),
    .cmd_o (cmd)
  );

  cfba_dp #(
    .BLOCK_COUNT(BLOCK_COUNT),
    .CACHE_SLOTS(CACHE_SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_type_i     (req_type_i),
    .block_index_i  (block_index_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .done_o         (done_o),
    .granted_block_o(granted_block_o),
    .status_o       (status_o)
  );

endmodule

`default_nettype wire

### hw/rtl/cfba_chk.sv
`default_nettype none

module cfba_chk
  import cfba_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                start,
  input wire logic                busy,
  input wire logic                done_o,
  input wire logic [BLOCK_W-1:0]  granted_block_o,
  input wire logic [STATUS_W-1:0] status_o
);

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted item");

  // A result is only shown once the block has gone idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // A failed request never grants a block.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (granted_block_o == '0))
    else $error("block granted on a failed request");

  // One item, one result: the strobe is never repeated back to back.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe repeated");

endmodule

bind chained_free_block_allocator cfba_chk u_cfba_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .granted_block_o(granted_block_o),
  .status_o       (status_o)
);

`default_nettype wire
